@@ hdl/box_iou_pkg.sv @@
// Shared types and sizing for the axis-aligned box IoU pipeline.
// No dependencies; used by box_iou_axis_aligned and box_iou_chk.
package box_iou_pkg;

    localparam int COORD_BITS      = 16;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int RATIO_BITS      = RATIO_FRAC_BITS + 1;

    // area products and the union (one carry bit above an area)
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int UNI_BITS   = PROD_BITS + 1;

    // front stages: corner compare, area multiply, union sum
    localparam int FRONT_STAGES = 3;
    // one restoring step per quotient bit
    localparam int DIV_STAGES   = RATIO_BITS;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES;

    typedef struct packed {
        logic [COORD_BITS-1:0] a_left;
        logic [COORD_BITS-1:0] a_top;
        logic [COORD_BITS-1:0] a_right;
        logic [COORD_BITS-1:0] a_bottom;
        logic [COORD_BITS-1:0] b_left;
        logic [COORD_BITS-1:0] b_top;
        logic [COORD_BITS-1:0] b_right;
        logic [COORD_BITS-1:0] b_bottom;
    } box_pair_t;

    typedef struct packed {
        logic [RATIO_BITS-1:0] ratio;
        logic                  overlaps;
    } box_iou_t;

endpackage

@@ hdl/box_iou_axis_aligned.sv @@
// Pipelined intersection-over-union of two axis-aligned boxes.
// Depends on box_iou_pkg (payload types, widths, stage counts).
//
// One box pair is taken per cycle on the pair channel while pair_ready is high; one
// result leaves per pair on the iou channel, in order. The pipeline is a restoring
// divider with one quotient bit per stage, RATIO_FRAC_BITS + 1 stages, behind three
// front stages (corner max/min and extents, the three area multipliers, the union sum).
// Each stage carries its own valid bit and a stage moves whenever any stage at or
// after it is empty, so bubbles are squeezed out during an output stall and a new
// pair is still accepted while a finished result waits. Once every stage is full
// and iou_ready is low, pair_ready drops. ratio is floor(inter * 2^F / union) with
// F fraction bits, 2^F for identical boxes; when the overlap is empty in either
// axis (including a box with right < left or bottom < top) ratio and overlaps are
// both zero. Coordinates are unsigned, in 1/16 pixel.
module box_iou_axis_aligned
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   pair_valid,
    output logic                   pair_ready,
    input  box_iou_pkg::box_pair_t pair,

    output logic                   iou_valid,
    input  logic                   iou_ready,
    output box_iou_pkg::box_iou_t  iou
);

    localparam int CW  = box_iou_pkg::COORD_BITS;
    localparam int PW  = box_iou_pkg::PROD_BITS;
    localparam int UW  = box_iou_pkg::UNI_BITS;
    localparam int QW  = box_iou_pkg::RATIO_BITS;
    localparam int NS  = box_iou_pkg::PIPE_STAGES;
    localparam int FS  = box_iou_pkg::FRONT_STAGES;
    localparam int DS  = box_iou_pkg::DIV_STAGES;

    // ---------------------------------------------------------------
    // Flow control: a stage loads when it or any later stage is empty,
    // or the result is being taken.
    // ---------------------------------------------------------------
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] adv;

    genvar gs;
    generate
        for (gs = 0; gs < NS; gs++)
        begin : g_adv
            assign adv[gs] = ~(&vld_reg[NS-1:gs]) | iou_ready;
        end
    endgenerate

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = pair_valid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign pair_ready = adv[0];
    assign iou_valid  = vld_reg[NS-1];

    // ---------------------------------------------------------------
    // Stage 0: overlap rectangle and box extents.
    // ---------------------------------------------------------------
    logic [CW-1:0] x0, x1, y0, y1;
    logic          ovl;

    logic [CW-1:0] dx_reg, dy_reg, wa_reg, ha_reg, wb_reg, hb_reg;
    logic [CW-1:0] dx_next, dy_next, wa_next, ha_next, wb_next, hb_next;
    logic          ovl0_reg, ovl0_next;

    always_comb
    begin
        x0  = (pair.a_left   > pair.b_left)   ? pair.a_left   : pair.b_left;
        y0  = (pair.a_top    > pair.b_top)    ? pair.a_top    : pair.b_top;
        x1  = (pair.a_right  < pair.b_right)  ? pair.a_right  : pair.b_right;
        y1  = (pair.a_bottom < pair.b_bottom) ? pair.a_bottom : pair.b_bottom;
        // a degenerate box can never pass both tests
        ovl = (x1 > x0) && (y1 > y0);

        // extents wrap when there is no overlap; masked at the end
        dx_next   = x1 - x0;
        dy_next   = y1 - y0;
        wa_next   = pair.a_right  - pair.a_left;
        ha_next   = pair.a_bottom - pair.a_top;
        wb_next   = pair.b_right  - pair.b_left;
        hb_next   = pair.b_bottom - pair.b_top;
        ovl0_next = ovl;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            wa_reg   <= wa_next;
            ha_reg   <= ha_next;
            wb_reg   <= wb_next;
            hb_reg   <= hb_next;
            ovl0_reg <= ovl0_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: intersection and box areas, three CW x CW multipliers.
    // ---------------------------------------------------------------
    logic [PW-1:0] inter1_reg, area_a_reg, area_b_reg;
    logic [PW-1:0] inter1_next, area_a_next, area_b_next;
    logic          ovl1_reg;

    always_comb
    begin
        inter1_next = PW'(dx_reg) * PW'(dy_reg);
        area_a_next = PW'(wa_reg) * PW'(ha_reg);
        area_b_next = PW'(wb_reg) * PW'(hb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            inter1_reg <= inter1_next;
            area_a_reg <= area_a_next;
            area_b_reg <= area_b_next;
            ovl1_reg   <= ovl0_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: union = area_a + area_b - inter, exact in UW bits when
    // the boxes overlap.
    // ---------------------------------------------------------------
    logic [UW-1:0] uni2_reg, uni2_next;
    logic [PW-1:0] inter2_reg;
    logic          ovl2_reg;

    assign uni2_next = UW'(area_a_reg) + UW'(area_b_reg) - UW'(inter1_reg);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            uni2_reg   <= uni2_next;
            inter2_reg <= inter1_reg;
            ovl2_reg   <= ovl1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Restoring divider, one quotient bit per stage, MSB first.
    // The first step has no shift: inter >= union gives the integer bit.
    // The remainder stays below the union, so UW bits hold it.
    // ---------------------------------------------------------------
    logic [UW-1:0] drem_reg [DS];
    logic [UW-1:0] duni_reg [DS];
    logic [QW-1:0] dquo_reg [DS];
    logic          dovl_reg [DS];

    genvar gd;
    generate
        for (gd = 0; gd < DS; gd++)
        begin : g_div
            logic [UW:0]   trial;
            logic [UW:0]   diff;
            logic [UW-1:0] uni_in;
            logic [QW-1:0] quo_in;
            logic          ovl_in;
            logic          take;
            logic [UW-1:0] rem_next;
            logic [QW-1:0] quo_next;

            if (gd == 0)
            begin : g_first
                assign trial  = (UW+1)'(inter2_reg);
                assign uni_in = uni2_reg;
                assign quo_in = '0;
                assign ovl_in = ovl2_reg;
            end
            else
            begin : g_next
                assign trial  = {drem_reg[gd-1], 1'b0};
                assign uni_in = duni_reg[gd-1];
                assign quo_in = dquo_reg[gd-1];
                assign ovl_in = dovl_reg[gd-1];
            end

            always_comb
            begin
                diff     = trial - {1'b0, uni_in};
                take     = (trial >= {1'b0, uni_in});
                rem_next = take ? diff[UW-1:0] : trial[UW-1:0];
                quo_next = {quo_in[QW-2:0], take};
                // last step: an empty overlap reports zero
                if ((gd == DS - 1) && !ovl_in)
                begin
                    quo_next = '0;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[FS+gd])
                begin
                    drem_reg[gd] <= rem_next;
                    duni_reg[gd] <= uni_in;
                    dquo_reg[gd] <= quo_next;
                    dovl_reg[gd] <= ovl_in;
                end
            end
        end
    endgenerate

    assign iou.ratio    = dquo_reg[DS-1];
    assign iou.overlaps = dovl_reg[DS-1];

endmodule

@@ hdl/box_iou_chk.sv @@
// Port-level checker for box_iou_axis_aligned, bound to every instance.
// Depends on box_iou_pkg for payload types and the ratio width.
module box_iou_chk
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   pair_ready,
    input logic                   iou_valid,
    input logic                   iou_ready,
    input box_iou_pkg::box_iou_t  iou
);

    localparam int QW = box_iou_pkg::RATIO_BITS;
    localparam logic [QW-1:0] RATIO_ONE = {1'b1, {(QW-1){1'b0}}};

    // result held until taken
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        iou_valid && !iou_ready |=> iou_valid)
        else $error("iou_valid dropped before transfer");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        iou_valid && !iou_ready |=> $stable(iou))
        else $error("iou payload changed during stall");

    // empty overlap reports a zero ratio
    a_no_ovl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        iou_valid && !iou.overlaps |-> iou.ratio == '0)
        else $error("non-zero ratio without overlap");

    // intersection never exceeds union
    a_ratio_max: assert property (@(posedge clk) disable iff (!rst_n)
        iou_valid |-> iou.ratio <= RATIO_ONE)
        else $error("ratio above one");

    // with the output stage empty the pipe must take a pair
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !iou_valid |-> pair_ready)
        else $error("pair_ready low with output stage empty");

endmodule

bind box_iou_axis_aligned box_iou_chk u_box_iou_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .pair_ready (pair_ready),
    .iou_valid  (iou_valid),
    .iou_ready  (iou_ready),
    .iou        (iou)
);
